### hdl/vau_pkg.sv
package vau_pkg;

    // Default number of fraction bits in every fixed-point component.
    localparam int DEF_FRAC_BITS = 16;

    // Equality tolerance after reset, in raw fixed-point units.
    localparam logic [15:0] TOL_RESET = 16'd33;

    // Stream widths: six 32-bit components plus a 31-bit length, padded to bytes.
    localparam int IN_W  = 224;
    localparam int OUT_W = 152;
    localparam int MODE_W = 3;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // One root bit per square-root step, one quotient bit per divider step.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_DOT   = 3'd2,
        OP_CROSS = 3'd3,
        OP_LEN   = 3'd4,
        OP_NORM  = 3'd5,
        OP_EQ    = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef logic signed [31:0] comp_t;

    // Decoded transaction as it leaves the front.
    typedef struct packed {
        op_t             op;
        comp_t [2:0]     a;
        comp_t [2:0]     b;
        logic [30:0]     target;
        comp_t [2:0]     pre;
        logic            pre_ovf;
        logic            eq;
    } item_t;

    // Partial result carried down the back pipeline.
    typedef struct packed {
        op_t                op;
        comp_t [2:0]        vec;
        logic signed [47:0] scalar;
        logic [30:0]        target;
        logic               eq;
        logic               ovf;
        logic               zero_len;
    } carry_t;

endpackage

### hdl/vau_front.sv
module vau_front
    import vau_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [MODE_W-1:0] s_tuser,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              pop,
    output logic              q_valid,
    output item_t             q_item
);

    logic [15:0]     tol_reg;
    item_t           item_in;
    item_t           fifo_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;

    assign push     = s_tvalid && s_tready;
    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    // Tolerance register; the user must write it only while the block is idle, the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Decode, finish add and subtract right away, and test each |a-b| against the tolerance.
    always_comb begin
        logic signed [32:0] ext_a;
        logic signed [32:0] ext_b;
        logic signed [32:0] sum;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [31:0]        sat_v;
        logic               sat_hit;
        item_in        = '0;
        item_in.op     = op_t'(s_tuser);
        item_in.target = s_tdata[222:192];
        item_in.eq     = (item_in.op == OP_EQ);
        for (int i = 0; i < 3; i++) begin
            item_in.a[i] = s_tdata[32*i +: 32];
            item_in.b[i] = s_tdata[96 + 32*i +: 32];
            ext_a   = {s_tdata[32*i + 31], s_tdata[32*i +: 32]};
            ext_b   = {s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]};
            diff    = ext_a - ext_b;
            sum     = (item_in.op == OP_SUB) ? diff : ext_a + ext_b;
            sat_hit = (sum[32] != sum[31]);
            sat_v   = sat_hit ? {sum[32], {31{~sum[32]}}} : sum[31:0];
            if (item_in.op == OP_ADD || item_in.op == OP_SUB) begin
                item_in.pre[i]  = sat_v;
                item_in.pre_ovf = item_in.pre_ovf | sat_hit;
            end
            mag = diff[32] ? 33'(-diff) : 33'(diff);
            if (mag >= {17'd0, tol_reg}) begin
                item_in.eq = 1'b0;
            end
        end
    end

    // Queue payload storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue fill level beyond its depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill level did not grow on a lone push");

endmodule

### hdl/vau_sqrt.sv
module vau_sqrt
    import vau_pkg::*;
(
    input  logic        aclk,
    input  logic        ce,
    input  logic [63:0] ss_in,
    output logic [31:0] root_out
);

    localparam int REM_W = 36;

    logic [REM_W-1:0] rem_in   [SQRT_STEPS];
    logic [REM_W-1:0] shifted  [SQRT_STEPS];
    logic [REM_W-1:0] trial    [SQRT_STEPS];
    logic [REM_W-1:0] rem_next [SQRT_STEPS];
    logic [REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [31:0]      root_in  [SQRT_STEPS];
    logic [31:0]      root_next[SQRT_STEPS];
    logic [31:0]      root_reg [SQRT_STEPS];
    logic [63:0]      rad_in   [SQRT_STEPS];
    logic [63:0]      rad_reg  [SQRT_STEPS];

    // One restoring step per stage: bring in two radicand bits, try root*4+1.
    always_comb begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        rad_in[0]  = ss_in;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            rad_in[k]  = rad_reg[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            shifted[k] = {rem_in[k][REM_W-3:0], rad_in[k][63:62]};
            trial[k]   = {2'b00, root_in[k], 2'b01};
            if (shifted[k] >= trial[k]) begin
                rem_next[k]  = shifted[k] - trial[k];
                root_next[k] = {root_in[k][30:0], 1'b1};
            end else begin
                rem_next[k]  = shifted[k];
                root_next[k] = {root_in[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= {rad_in[k][61:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[SQRT_STEPS-1];

endmodule

### hdl/vau_div.sv
module vau_div
    import vau_pkg::*;
(
    input  logic                 aclk,
    input  logic                 ce,
    input  logic [62:0]          num_in,
    input  logic [31:0]          den_in,
    output logic [DIV_STEPS-1:0] quo_out
);

    logic [31:0]          rem_in   [DIV_STEPS];
    logic [31:0]          rem_next [DIV_STEPS];
    logic [31:0]          rem_reg  [DIV_STEPS];
    logic [32:0]          part     [DIV_STEPS];
    logic [30:0]          low_in   [DIV_STEPS];
    logic [30:0]          low_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_in   [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg  [DIV_STEPS];
    logic [31:0]          dv_in    [DIV_STEPS];
    logic [31:0]          dv_reg   [DIV_STEPS];

    // Long division, one quotient bit per stage; the upper half is already below the divisor.
    always_comb begin
        rem_in[0] = num_in[62:31];
        low_in[0] = num_in[30:0];
        quo_in[0] = '0;
        dv_in[0]  = den_in;
        for (int k = 1; k < DIV_STEPS; k++) begin
            rem_in[k] = rem_reg[k-1];
            low_in[k] = low_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            dv_in[k]  = dv_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            part[k] = {rem_in[k], low_in[k][30]};
            if (part[k] >= {1'b0, dv_in[k]}) begin
                rem_next[k] = 32'(part[k] - {1'b0, dv_in[k]});
                quo_next[k] = {quo_in[k][DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next[k] = part[k][31:0];
                quo_next[k] = {quo_in[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                low_reg[k] <= {low_in[k][29:0], 1'b0};
                dv_reg[k]  <= dv_in[k];
            end
        end
    end

    assign quo_out = quo_reg[DIV_STEPS-1];

endmodule

### hdl/vau_back.sv
module vau_back
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int NST = 5 + SQRT_STEPS + DIV_STEPS;
    localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [65:0] S48_MAX = (66'sd1 <<< 47) - 66'sd1;
    localparam logic signed [65:0] S48_MIN = -(66'sd1 <<< 47);

    logic               ce;
    logic [NST-1:0]     vld_reg;

    logic signed [31:0] mul_a [6];
    logic signed [31:0] mul_b [6];
    logic signed [63:0] prod1_reg [6];
    item_t              item1_reg;

    logic signed [65:0] lane_next [3];
    logic signed [65:0] lane_reg  [3];
    item_t              item2_reg;

    logic signed [65:0] rnd [3];
    carry_t             c3_next;
    carry_t             d1_reg [SQRT_STEPS];
    logic [31:0]        root;

    carry_t             c35_next;
    carry_t             c35_reg;
    logic [62:0]        prod35_reg [3];
    logic [31:0]        len35_reg;
    carry_t             c36_reg;
    logic [62:0]        num36_reg [3];
    logic [31:0]        den36_reg;

    logic [DIV_STEPS-1:0] quo [3];
    carry_t             d2_reg [DIV_STEPS];
    carry_t             out_next;
    carry_t             out_reg;

    // The whole pipeline advances unless a finished result is held at the output.
    assign ce       = !vld_reg[NST-1] || m_tready;
    assign pop      = ce && q_valid;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {6'd0, out_reg.ovf, out_reg.eq, out_reg.scalar, out_reg.vec};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], q_valid};
        end
    end

    // Operand routing for the six shared multipliers.
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            mul_a[j] = '0;
            mul_b[j] = '0;
        end
        unique case (q_item.op)
            OP_CROSS: begin
                mul_a[0] = q_item.a[1]; mul_b[0] = q_item.b[2];
                mul_a[1] = q_item.a[2]; mul_b[1] = q_item.b[1];
                mul_a[2] = q_item.a[2]; mul_b[2] = q_item.b[0];
                mul_a[3] = q_item.a[0]; mul_b[3] = q_item.b[2];
                mul_a[4] = q_item.a[0]; mul_b[4] = q_item.b[1];
                mul_a[5] = q_item.a[1]; mul_b[5] = q_item.b[0];
            end
            OP_LEN, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = q_item.a[i];
                    mul_b[i] = q_item.a[i];
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = q_item.a[i];
                    mul_b[i] = q_item.b[i];
                end
            end
        endcase
    end

    // Product stage.
    always_ff @(posedge aclk) begin
        if (ce) begin
            item1_reg <= q_item;
            for (int j = 0; j < 6; j++) begin
                prod1_reg[j] <= 64'(mul_a[j]) * 64'(mul_b[j]);
            end
        end
    end

    // Sum stage: dot sum or sum of squares in lane 0, cross differences in all lanes.
    always_comb begin
        if (item1_reg.op == OP_CROSS) begin
            lane_next[0] = 66'(prod1_reg[0]) - 66'(prod1_reg[1]);
        end else begin
            lane_next[0] = 66'(prod1_reg[0]) + 66'(prod1_reg[1]) + 66'(prod1_reg[2]);
        end
        lane_next[1] = 66'(prod1_reg[2]) - 66'(prod1_reg[3]);
        lane_next[2] = 66'(prod1_reg[4]) - 66'(prod1_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            item2_reg <= item1_reg;
            for (int i = 0; i < 3; i++) begin
                lane_reg[i] <= lane_next[i];
            end
        end
    end

    // Round to nearest, saturate, and pick the result of the simple modes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (lane_reg[i] + HALF) >>> FRAC_BITS;
        end
        c3_next          = '0;
        c3_next.op       = item2_reg.op;
        c3_next.target   = item2_reg.target;
        c3_next.eq       = item2_reg.eq;
        unique case (item2_reg.op)
            OP_ADD, OP_SUB: begin
                c3_next.vec = item2_reg.pre;
                c3_next.ovf = item2_reg.pre_ovf;
            end
            OP_DOT: begin
                if (rnd[0] > S48_MAX) begin
                    c3_next.scalar = S48_MAX[47:0];
                    c3_next.ovf    = 1'b1;
                end else if (rnd[0] < S48_MIN) begin
                    c3_next.scalar = S48_MIN[47:0];
                    c3_next.ovf    = 1'b1;
                end else begin
                    c3_next.scalar = rnd[0][47:0];
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    if (rnd[i] > S32_MAX) begin
                        c3_next.vec[i] = S32_MAX[31:0];
                        c3_next.ovf    = 1'b1;
                    end else if (rnd[i] < S32_MIN) begin
                        c3_next.vec[i] = S32_MIN[31:0];
                        c3_next.ovf    = 1'b1;
                    end else begin
                        c3_next.vec[i] = rnd[i][31:0];
                    end
                end
            end
            OP_NORM: begin
                c3_next.vec = item2_reg.a;
            end
            default: begin
            end
        endcase
    end

    // Square root of the sum of squares, one root bit per stage.
    vau_sqrt u_sqrt (
        .aclk     (aclk),
        .ce       (ce),
        .ss_in    (lane_reg[0][63:0]),
        .root_out (root)
    );

    // Delay line that keeps each transaction aligned with its square root.
    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_reg[0] <= c3_next;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                d1_reg[k] <= d1_reg[k-1];
            end
        end
    end

    // Length is known: record it and scale each magnitude by the target.
    always_comb begin
        c35_next = d1_reg[SQRT_STEPS-1];
        if (c35_next.op == OP_LEN) begin
            c35_next.scalar = {16'd0, root};
        end
        if (c35_next.op == OP_NORM) begin
            c35_next.zero_len = (root == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c35_reg   <= c35_next;
            len35_reg <= root;
            for (int i = 0; i < 3; i++) begin
                if (c35_next.vec[i][31]) begin
                    prod35_reg[i] <= 63'($unsigned(32'(-c35_next.vec[i])))
                                     * 63'(c35_next.target);
                end else begin
                    prod35_reg[i] <= 63'(c35_next.vec[i]) * 63'(c35_next.target);
                end
            end
        end
    end

    // Add half the length so that the quotient rounds to nearest.
    always_ff @(posedge aclk) begin
        if (ce) begin
            c36_reg   <= c35_reg;
            den36_reg <= len35_reg;
            for (int i = 0; i < 3; i++) begin
                num36_reg[i] <= prod35_reg[i] + 63'(len35_reg >> 1);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        vau_div u_div (
            .aclk    (aclk),
            .ce      (ce),
            .num_in  (num36_reg[i]),
            .den_in  (den36_reg),
            .quo_out (quo[i])
        );
    end

    // Delay line that keeps each transaction aligned with its quotients.
    always_ff @(posedge aclk) begin
        if (ce) begin
            d2_reg[0] <= c36_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end

    // Apply signs to the normalized components and handle a zero-length vector.
    always_comb begin
        out_next = d2_reg[DIV_STEPS-1];
        if (out_next.op == OP_NORM && out_next.target != '0) begin
            if (out_next.zero_len) begin
                out_next.vec = '0;
                out_next.ovf = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (d2_reg[DIV_STEPS-1].vec[i][31]) begin
                        out_next.vec[i] = -{1'b0, quo[i]};
                    end else begin
                        out_next.vec[i] = {1'b0, quo[i]};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline occupancy changed during a stall");

    a_eq_only_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.op != OP_EQ |-> !out_reg.eq)
        else $error("equality flag set outside the compare mode");

    a_len_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.op == OP_LEN |-> out_reg.vec == '0 && !out_reg.ovf)
        else $error("length result carries vector data or overflow");

endmodule

### hdl/vector3_arith_unit.sv
// Three-component fixed-point vector unit.
// Input channel s_*: one transaction per operation. s_tuser carries the mode
// (add, subtract, dot, cross, length, normalize, approximate equality); s_tdata
// carries vectors A and B and the normalize target length.
// Output channel m_*: exactly one result transaction per input transaction, in order.
// Configuration: cfg_wr_en with cfg_wr_data writes the equality tolerance; write
// it only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled. Between input
// accept and m_tvalid every transaction passes through the 32-stage square-root
// pipeline and the 31-stage quotient pipeline, plus multiply, sum, scaling, rounding
// and output stages. A two-entry queue separates the input decode from the
// arithmetic pipeline.
// Reset: aresetn low clears the queue and all valid bits and restores the
// tolerance to 33; results in flight are dropped.
// Stall: while m_tvalid is high and m_tready low the arithmetic pipeline holds;
// the queue keeps accepting until it is full, then s_tready drops.
module vector3_arith_unit
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (32 bits each), target_length (31 bits), one pad bit
    input  logic [IN_W-1:0]   s_tdata,
    // mode
    input  logic [MODE_W-1:0] s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // res_x, res_y, res_z (32 bits each), scalar (48), is_equal, overflow, six pad bits
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    logic  q_valid;
    logic  pop;
    item_t q_item;

    vau_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop         (pop),
        .q_valid     (q_valid),
        .q_item      (q_item)
    );

    vau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
